// File: hdl/qoie_pkg.sv
package qoie_pkg;

    // QOI op codes
    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hC0;
    localparam logic [7:0] OP_RGB   = 8'hFE;
    localparam logic [7:0] OP_RGBA  = 8'hFF;

    // Stream layout
    localparam logic [5:0] RUN_MAX   = 6'd62;
    localparam int         HDR_LEN   = 14;
    localparam int         END_LEN   = 8;
    localparam int         SEQ_MAX   = 28;
    localparam int         SEQ_W     = $clog2(SEQ_MAX + 1);

    // Color index geometry
    localparam int IDX_DEPTH = 64;
    localparam int IDX_AW    = $clog2(IDX_DEPTH);
    localparam int PIX_W     = 32;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_CHANNELS = 2'd2;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } pixel_t;

    localparam pixel_t PIX_START = '{a: 8'hFF, b: 8'h00, g: 8'h00, r: 8'h00};

    // Index slot: (3r + 5g + 7b + 11a) mod 64
    function automatic logic [IDX_AW-1:0] pix_hash(input pixel_t p);
        logic [IDX_AW-1:0] r6;
        logic [IDX_AW-1:0] g6;
        logic [IDX_AW-1:0] b6;
        logic [IDX_AW-1:0] a6;
        r6 = p.r[IDX_AW-1:0];
        g6 = p.g[IDX_AW-1:0];
        b6 = p.b[IDX_AW-1:0];
        a6 = p.a[IDX_AW-1:0];
        return IDX_AW'(r6 * IDX_AW'(3)) + IDX_AW'(g6 * IDX_AW'(5))
             + IDX_AW'(b6 * IDX_AW'(7)) + IDX_AW'(a6 * IDX_AW'(11));
    endfunction

endpackage

// File: hdl/qoie_ram.sv
module qoie_ram #(
    parameter int WIDTH = qoie_pkg::PIX_W,
    parameter int DEPTH = qoie_pkg::IDX_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/qoi_image_encoder.sv
// Channel  Direction  Beat content
// s_*      in         one RGBA pixel; s_tlast marks the final pixel of the image
// m_*      out        one byte of the QOI stream; tuser flags last byte of a pixel
// cfg_*    in         register write: 0 width, 1 height, 2 channel count
//
// A pixel sits in one work register while its bytes go out, one byte per cycle
// while the output is not stalled. A pixel that adds nothing (a growing run) emits no
// byte; any other emits 1 to 28 bytes through the single output byte register.
// Reset clears the previous pixel, run count, header flag and the index valid
// bits at once; there is no clearing pass. Output stalls back up into s_tready.
module qoi_image_encoder (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic        s_tlast,   // last_pixel
    // byte output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic [0:0]  m_tuser,   // item_done[0]
    output logic        m_tlast    // stream_end
);

    localparam int AW = qoie_pkg::IDX_AW;
    localparam int SW = qoie_pkg::SEQ_W;

    // Configuration registers
    logic [31:0] width_reg;
    logic [31:0] height_reg;
    logic [2:0]  chan_reg;

    // Work stage
    logic                 s1_valid_reg;
    qoie_pkg::pixel_t     s1_pix_reg;
    logic                 s1_last_reg;
    logic [AW-1:0]        s1_h_reg;
    logic                 s1_ivld_reg;
    logic                 s1_byp_reg;
    qoie_pkg::pixel_t     s1_byp_pix_reg;
    logic [SW-1:0]        k_reg;

    // Image state
    qoie_pkg::pixel_t     prev_reg;
    logic [5:0]           run_reg;
    logic                 hdr_sent_reg;
    logic [qoie_pkg::IDX_DEPTH-1:0] ivalid_reg;
    logic [qoie_pkg::IDX_DEPTH-1:0] ivalid_next;

    // Output register
    logic       o_valid_reg;
    logic [7:0] o_byte_reg;
    logic       o_done_reg;
    logic       o_end_reg;

    // Input side
    qoie_pkg::pixel_t in_pix;
    logic [AW-1:0]    in_h;
    logic             accept;

    // Stage combinational
    logic [31:0]      ram_q;
    qoie_pkg::pixel_t idx_pix;
    logic             same;
    logic             hit;
    logic [5:0]       run_inc;
    logic             emit_run;
    logic [7:0]       run_byte;
    logic signed [7:0] dr;
    logic signed [7:0] dg;
    logic signed [7:0] db;
    logic signed [8:0] drg;
    logic signed [8:0] dbg;
    logic             diff_ok;
    logic             luma_ok;
    logic [7:0]       diff_byte;
    logic [7:0]       luma0;
    logic [7:0]       luma1;
    logic [SW-1:0]    n_hdr;
    logic [SW-1:0]    n_run;
    logic [SW-1:0]    n_op;
    logic [SW-1:0]    n_end;
    logic [SW-1:0]    total;
    logic [SW-1:0]    k1;
    logic [SW-1:0]    k2;
    logic [SW-1:0]    k3;
    logic [7:0]       hdr_byte;
    logic [7:0]       op_byte;
    logic [7:0]       byte_next;
    logic             seq_last;
    logic             push;
    logic             s1_done;
    logic             idx_wr;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 32'd1;
            height_reg <= 32'd1;
            chan_reg   <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qoie_pkg::CFG_WIDTH:    width_reg  <= cfg_data;
                qoie_pkg::CFG_HEIGHT:   height_reg <= cfg_data;
                qoie_pkg::CFG_CHANNELS: chan_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Unpack the pixel, force alpha for three channels, hash it
    always_comb
    begin
        in_pix.r = s_tdata[7:0];
        in_pix.g = s_tdata[15:8];
        in_pix.b = s_tdata[23:16];
        in_pix.a = (chan_reg == 3'd3) ? 8'hFF : s_tdata[31:24];
        in_h     = qoie_pkg::pix_hash(in_pix);
    end

    assign s_tready = !s1_valid_reg || s1_done;
    assign accept   = s_tvalid && s_tready;

    // Color index memory
    qoie_ram #(
        .WIDTH (qoie_pkg::PIX_W),
        .DEPTH (qoie_pkg::IDX_DEPTH)
    ) u_index (
        .clk   (clk),
        .we    (idx_wr),
        .waddr (s1_h_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (in_h),
        .rdata (ram_q)
    );

    // Index entry, pixel compare and run logic
    always_comb
    begin
        if (!s1_ivld_reg)
        begin
            idx_pix = '0;
        end
        else if (s1_byp_reg)
        begin
            idx_pix = s1_byp_pix_reg;
        end
        else
        begin
            idx_pix = qoie_pkg::pixel_t'(ram_q);
        end
        same     = (s1_pix_reg == prev_reg);
        hit      = (idx_pix == s1_pix_reg);
        run_inc  = run_reg + 6'd1;
        emit_run = same ? ((run_inc == qoie_pkg::RUN_MAX) || s1_last_reg)
                        : (run_reg != 6'd0);
        run_byte = qoie_pkg::OP_RUN | {2'b00, (same ? run_reg : run_reg - 6'd1)};
    end

    // Channel deltas and op choice
    always_comb
    begin
        dr  = $signed(s1_pix_reg.r - prev_reg.r);
        dg  = $signed(s1_pix_reg.g - prev_reg.g);
        db  = $signed(s1_pix_reg.b - prev_reg.b);
        drg = 9'(dr) - 9'(dg);
        dbg = 9'(db) - 9'(dg);
        diff_ok = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
               && (db >= -8'sd2) && (db <= 8'sd1);
        luma_ok = (dg >= -8'sd32) && (dg <= 8'sd31) && (drg >= -9'sd8) && (drg <= 9'sd7)
               && (dbg >= -9'sd8) && (dbg <= 9'sd7);
        diff_byte = qoie_pkg::OP_DIFF | {2'b00, 2'(dr + 8'sd2), 2'(dg + 8'sd2),
                                         2'(db + 8'sd2)};
        luma0 = qoie_pkg::OP_LUMA | {2'b00, 6'(dg + 8'sd32)};
        luma1 = {4'(drg + 9'sd8), 4'(dbg + 9'sd8)};

        if (same)
        begin
            n_op = SW'(0);
        end
        else if (hit)
        begin
            n_op = SW'(1);
        end
        else if (s1_pix_reg.a == prev_reg.a)
        begin
            n_op = diff_ok ? SW'(1) : (luma_ok ? SW'(2) : SW'(4));
        end
        else
        begin
            n_op = SW'(5);
        end
        n_hdr = hdr_sent_reg ? SW'(0) : SW'(qoie_pkg::HDR_LEN);
        n_run = emit_run ? SW'(1) : SW'(0);
        n_end = s1_last_reg ? SW'(qoie_pkg::END_LEN) : SW'(0);
        total = n_hdr + n_run + n_op + n_end;
    end

    // Header byte by position
    always_comb
    begin
        case (k_reg)
            SW'(0):  hdr_byte = 8'h71;
            SW'(1):  hdr_byte = 8'h6F;
            SW'(2):  hdr_byte = 8'h69;
            SW'(3):  hdr_byte = 8'h66;
            SW'(4):  hdr_byte = width_reg[31:24];
            SW'(5):  hdr_byte = width_reg[23:16];
            SW'(6):  hdr_byte = width_reg[15:8];
            SW'(7):  hdr_byte = width_reg[7:0];
            SW'(8):  hdr_byte = height_reg[31:24];
            SW'(9):  hdr_byte = height_reg[23:16];
            SW'(10): hdr_byte = height_reg[15:8];
            SW'(11): hdr_byte = height_reg[7:0];
            SW'(12): hdr_byte = {5'b00000, chan_reg};
            default: hdr_byte = 8'h00;
        endcase
    end

    // Op byte by position within the op
    always_comb
    begin
        k1 = k_reg - n_hdr;
        k2 = k1 - n_run;
        k3 = k2 - n_op;
        op_byte = 8'h00;
        if (hit)
        begin
            op_byte = qoie_pkg::OP_INDEX | {2'b00, s1_h_reg};
        end
        else if (n_op == SW'(1))
        begin
            op_byte = diff_byte;
        end
        else if (n_op == SW'(2))
        begin
            op_byte = (k2 == SW'(0)) ? luma0 : luma1;
        end
        else
        begin
            case (k2)
                SW'(0):  op_byte = (n_op == SW'(5)) ? qoie_pkg::OP_RGBA : qoie_pkg::OP_RGB;
                SW'(1):  op_byte = s1_pix_reg.r;
                SW'(2):  op_byte = s1_pix_reg.g;
                SW'(3):  op_byte = s1_pix_reg.b;
                default: op_byte = s1_pix_reg.a;
            endcase
        end
    end

    // Pick the byte: header, run, op, end marker
    always_comb
    begin
        if (k_reg < n_hdr)
        begin
            byte_next = hdr_byte;
        end
        else if (k1 < n_run)
        begin
            byte_next = run_byte;
        end
        else if (k2 < n_op)
        begin
            byte_next = op_byte;
        end
        else
        begin
            byte_next = (k3 == SW'(qoie_pkg::END_LEN - 1)) ? 8'h01 : 8'h00;
        end
        seq_last = (k_reg == total - SW'(1));
        push     = s1_valid_reg && (total != SW'(0)) && (!o_valid_reg || m_tready);
        s1_done  = s1_valid_reg && ((total == SW'(0)) || (push && seq_last));
        idx_wr   = s1_done && !same;
    end

    // Index valid bits: set on write, drop all at end of image
    always_comb
    begin
        ivalid_next = ivalid_reg;
        if (s1_done)
        begin
            if (s1_last_reg)
            begin
                ivalid_next = '0;
            end
            else if (!same)
            begin
                ivalid_next[s1_h_reg] = 1'b1;
            end
        end
    end

    // Work stage load and byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            k_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done)
            begin
                k_reg <= '0;
            end
            else if (push)
            begin
                k_reg <= k_reg + SW'(1);
            end
        end
    end

    // Hold pixel payload; catch an index write landing on the same slot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg     <= in_pix;
            s1_last_reg    <= s_tlast;
            s1_h_reg       <= in_h;
            s1_ivld_reg    <= ivalid_next[in_h];
            s1_byp_reg     <= idx_wr && !s1_last_reg && (s1_h_reg == in_h);
            s1_byp_pix_reg <= s1_pix_reg;
        end
    end

    // Image state advances when a pixel finishes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= qoie_pkg::PIX_START;
            run_reg      <= '0;
            hdr_sent_reg <= 1'b0;
            ivalid_reg   <= '0;
        end
        else
        begin
            ivalid_reg <= ivalid_next;
            if (s1_done)
            begin
                hdr_sent_reg <= !s1_last_reg;
                prev_reg     <= s1_last_reg ? qoie_pkg::PIX_START : s1_pix_reg;
                run_reg      <= (s1_last_reg || !same || emit_run) ? 6'd0 : run_inc;
            end
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            o_byte_reg <= byte_next;
            o_done_reg <= seq_last;
            o_end_reg  <= seq_last && s1_last_reg;
        end
    end

    assign m_tvalid   = o_valid_reg;
    assign m_tdata    = o_byte_reg;
    assign m_tuser[0] = o_done_reg;
    assign m_tlast    = o_end_reg;

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE      = 8;
    localparam int          LONG_HOLD   = 250;
    localparam int          MAX_PRINTS  = 40;
    localparam logic [31:0] HDR_TAG     = "qoif";

    typedef struct {
        logic [7:0] data;
        logic       done;
        logic       end_mark;
    } stream_byte_t;

    // Byte-stream predictor and checker for the encoder
    class qoi_byte_scoreboard;
        qoie_pkg::pixel_t palette[qoie_pkg::IDX_DEPTH];
        qoie_pkg::pixel_t last_px;
        int             run_len;
        bit             header_done;
        logic [31:0]    width_reg;
        logic [31:0]    height_reg;
        logic [2:0]     chans;
        logic [7:0]     seq[$];
        stream_byte_t   pending_bytes[$];
        int             errors;
        int             byte_count;

        function new();
            width_reg  = 32'd1;
            height_reg = 32'd1;
            chans      = 3'd4;
            errors     = 0;
            byte_count = 0;
            clear_image();
        endfunction

        function void clear_image();
            foreach (palette[k])
                palette[k] = '0;
            last_px     = qoie_pkg::PIX_START;
            run_len     = 0;
            header_done = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                qoie_pkg::CFG_WIDTH:    width_reg  = value;
                qoie_pkg::CFG_HEIGHT:   height_reg = value;
                qoie_pkg::CFG_CHANNELS: chans      = value[2:0];
                default: ;
            endcase
        endfunction

        function void push(logic [7:0] value);
            seq.insert(seq.size(), value);
        endfunction

        function void flush_run();
            if (run_len > 0)
            begin
                push(qoie_pkg::OP_RUN | 8'(run_len - 1));
                run_len = 0;
            end
        endfunction

        // Wrapped channel difference, -128..127
        function int wrap_delta(logic [7:0] x, logic [7:0] y);
            logic signed [7:0] d;
            d = x - y;
            return d;
        endfunction

        // Work out every byte that one accepted pixel causes
        function void take_pixel(logic [31:0] beat, logic final_px);
            qoie_pkg::pixel_t px;
            int           slot;
            int           dr;
            int           dg;
            int           db;
            int           drg;
            int           dbg;
            stream_byte_t e;
            px = beat;
            if (chans == 3'd3)
                px.a = 8'hFF;

            if (!header_done)
            begin
                push(HDR_TAG[31:24]);
                push(HDR_TAG[23:16]);
                push(HDR_TAG[15:8]);
                push(HDR_TAG[7:0]);
                push(width_reg[31:24]);
                push(width_reg[23:16]);
                push(width_reg[15:8]);
                push(width_reg[7:0]);
                push(height_reg[31:24]);
                push(height_reg[23:16]);
                push(height_reg[15:8]);
                push(height_reg[7:0]);
                push({5'd0, chans});
                push(8'h00);
                header_done = 1;
            end

            if (px == last_px)
            begin
                run_len++;
                // emit at the run limit and restart the count
                if (run_len >= int'(qoie_pkg::RUN_MAX))
                    flush_run();
            end
            else
            begin
                flush_run();
                slot = (px.r * 3 + px.g * 5 + px.b * 7 + px.a * 11) & 63;
                if (palette[slot] == px)
                    push(qoie_pkg::OP_INDEX | 8'(slot));
                else
                begin
                    palette[slot] = px;
                    if (px.a == last_px.a)
                    begin
                        dr  = wrap_delta(px.r, last_px.r);
                        dg  = wrap_delta(px.g, last_px.g);
                        db  = wrap_delta(px.b, last_px.b);
                        drg = dr - dg;
                        dbg = db - dg;
                        if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1)
                            push(qoie_pkg::OP_DIFF
                                 | 8'(((dr + 2) << 4) | ((dg + 2) << 2) | (db + 2)));
                        else if (dg >= -32 && dg <= 31 && drg >= -8 && drg <= 7
                                 && dbg >= -8 && dbg <= 7)
                        begin
                            push(qoie_pkg::OP_LUMA | 8'(dg + 32));
                            push(8'(((drg + 8) << 4) | (dbg + 8)));
                        end
                        else
                        begin
                            push(qoie_pkg::OP_RGB);
                            push(px.r);
                            push(px.g);
                            push(px.b);
                        end
                    end
                    else
                    begin
                        push(qoie_pkg::OP_RGBA);
                        push(px.r);
                        push(px.g);
                        push(px.b);
                        push(px.a);
                    end
                end
            end
            last_px = px;

            // close the image: open run, end marker, fresh state
            if (final_px)
            begin
                flush_run();
                repeat (7)
                    push(8'h00);
                push(8'h01);
                clear_image();
            end

            foreach (seq[k])
            begin
                e.data     = seq[k];
                e.done     = (k == seq.size() - 1);
                e.end_mark = final_px && e.done;
                pending_bytes.insert(pending_bytes.size(), e);
            end
            seq.delete();
        endfunction

        task report(string field, logic [7:0] got, logic [7:0] want);
            errors++;
            // keep the log short when the stream goes badly wrong
            if (errors <= MAX_PRINTS)
                $display("mismatch on %s at byte %0d: got %h, expected %h",
                         field, byte_count, got, want);
        endtask

        task check_byte(logic [7:0] data, logic done, logic tail);
            stream_byte_t e;
            byte_count++;
            if (pending_bytes.size() == 0)
            begin
                report("unexpected beat", data, 8'h00);
                return;
            end
            e = pending_bytes.pop_front();
            if (data !== e.data)
                report("out_byte", data, e.data);
            if (done !== e.done)
                report("item_done", {7'd0, done}, {7'd0, e.done});
            if (tail !== e.end_mark)
                report("stream_end", {7'd0, tail}, {7'd0, e.end_mark});
        endtask

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = qoie_pkg::CFG_WIDTH;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    qoi_byte_scoreboard sb = new();

    qoie_pkg::pixel_t gen_prev = qoie_pkg::PIX_START;
    qoie_pkg::pixel_t recent[16];
    int     recent_ptr = 0;
    bit     quiet = 0;
    bit     hold_req = 0;
    int     cycles = 0;

    qoi_image_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Sample register writes and both handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.take_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_byte(m_tdata, m_tuser[0], m_tlast);
        end
    end

    // Byte sink: random stall bursts, one long hold-off on request, none at the end
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 0;
            end
            else if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic qoie_pkg::pixel_t rgba(int r, int g, int b, int a);
        qoie_pkg::pixel_t p;
        p.r = 8'(r);
        p.g = 8'(g);
        p.b = 8'(b);
        p.a = 8'(a);
        return p;
    endfunction

    // Pick the next pixel so that every op shows up often
    function automatic qoie_pkg::pixel_t next_pixel();
        qoie_pkg::pixel_t p;
        int     mode;
        int     dg;
        p    = gen_prev;
        mode = $urandom_range(0, 99);
        if (mode < 18)
            p = gen_prev;
        else if (mode < 38)
        begin
            p.r = gen_prev.r + 8'($urandom_range(0, 3)) - 8'd2;
            p.g = gen_prev.g + 8'($urandom_range(0, 3)) - 8'd2;
            p.b = gen_prev.b + 8'($urandom_range(0, 3)) - 8'd2;
        end
        else if (mode < 55)
        begin
            dg  = int'($urandom_range(0, 63)) - 32;
            p.g = gen_prev.g + 8'(dg);
            p.r = gen_prev.r + 8'(dg + int'($urandom_range(0, 15)) - 8);
            p.b = gen_prev.b + 8'(dg + int'($urandom_range(0, 15)) - 8);
        end
        else if (mode < 70)
            p = recent[$urandom_range(0, 15)];
        else if (mode < 85)
        begin
            p   = qoie_pkg::pixel_t'($urandom());
            p.a = gen_prev.a;
        end
        else if (mode < 90)
            p = rgba($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                     $urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255);
        else
            p = qoie_pkg::pixel_t'($urandom());
        return p;
    endfunction

    // Offer one pixel and hold it until the block takes it
    task automatic send_pixel(qoie_pkg::pixel_t p, bit final_px);
        if (!quiet && !hold_req && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        s_tlast  <= final_px;
        do
            @(posedge clk);
        while (!s_tready);
        recent[recent_ptr] = p;
        recent_ptr = (recent_ptr + 1) % 16;
        gen_prev = final_px ? qoie_pkg::PIX_START : p;
    endtask

    task automatic send_random(int count);
        repeat (count)
            send_pixel(next_pixel(), $urandom_range(0, 24) == 0);
    endtask

    task automatic send_run(int count);
        repeat (count)
            send_pixel(gen_prev, 1'b0);
    endtask

    // Stop offering and wait until every expected byte is out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all three registers while the block is idle
    task automatic program_regs(logic [31:0] w, logic [31:0] h, logic [2:0] ch);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= qoie_pkg::CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= qoie_pkg::CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= qoie_pkg::CFG_CHANNELS;
        cfg_data  <= {29'($urandom()), ch};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        foreach (recent[k])
            recent[k] = qoie_pkg::pixel_t'($urandom());
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: runs, every op, index slot zero, end of image with open run
        send_pixel(rgba(0, 0, 0, 255), 1'b0);
        send_pixel(rgba(0, 0, 0, 255), 1'b0);
        send_pixel(rgba(1, 0, 255, 255), 1'b0);
        send_pixel(rgba(255, 255, 255, 255), 1'b0);
        send_pixel(rgba(10, 5, 8, 255), 1'b0);
        send_pixel(rgba(200, 0, 100, 255), 1'b0);
        send_pixel(rgba(200, 0, 100, 0), 1'b0);
        send_pixel(rgba(10, 5, 8, 255), 1'b0);
        send_pixel(rgba(0, 0, 0, 0), 1'b0);
        send_pixel(rgba(0, 0, 0, 0), 1'b1);

        // Three channels: alpha forced opaque
        program_regs(32'hFFFF_FFFF, 32'd1, 3'd3);
        send_pixel(rgba(255, 128, 7, 0), 1'b0);
        send_pixel(rgba(255, 128, 7, 17), 1'b0);
        send_pixel(rgba(0, 0, 0, 255), 1'b1);

        // Odd channel counts go into the header as written
        program_regs(32'd1, 32'hFFFF_FFFF, 3'd0);
        send_pixel(rgba(9, 9, 9, 9), 1'b0);
        send_pixel(rgba(9, 9, 9, 200), 1'b0);
        send_pixel(rgba(0, 255, 0, 255), 1'b1);
        program_regs(32'h8000_0001, 32'h0001_0000, 3'd7);
        send_pixel(rgba(255, 255, 255, 255), 1'b0);
        send_pixel(rgba(255, 255, 255, 255), 1'b1);

        // Random phases; registers change only between them
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: program_regs($urandom(), $urandom(), 3'd4);
                1: program_regs(32'd1, 32'd1, 3'd3);
                2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4);
                3: program_regs($urandom(), $urandom(), 3'd5);
                4: program_regs($urandom(), $urandom_range(1, 64), 3'd3);
                5: program_regs($urandom_range(1, 64), $urandom(), 3'd7);
                6: program_regs($urandom(), $urandom(), 3'd4);
                default: program_regs($urandom(), $urandom(), 3'd4);
            endcase
            if (ph == 0)
                hold_req = 1;
            if (ph == 7)
                quiet = 1;
            send_random(20);
            if (ph == 2)
                send_run(62);
            if (ph == 4)
                send_run(64);
            send_random(20);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
